// ===== rtl/core/pmconv_pkg.sv =====
`timescale 1ns / 1ps
package pmconv_pkg;
    localparam int CHANNELS    = 4;
    localparam int IMG_DIM     = 16;
    localparam int KER_DIM     = 3;
    localparam int PAD         = 1;
    localparam int FILTERS     = 8;
    localparam int OUT_SIZE    = IMG_DIM + 2 * PAD - KER_DIM + 1;
    localparam int ROW_CAP     = 16;
    localparam int COUNT       = (OUT_SIZE > ROW_CAP) ? ROW_CAP : OUT_SIZE;
    localparam int IMG_DEPTH   = CHANNELS * IMG_DIM * IMG_DIM;
    localparam int WGT_DEPTH   = FILTERS * CHANNELS * KER_DIM * KER_DIM;
    localparam int IMG_AW      = $clog2(IMG_DEPTH);
    localparam int WGT_AW      = $clog2(WGT_DEPTH);
    localparam int CNT_W       = $clog2(COUNT + 1);
    localparam int COL_W       = (COUNT > 1) ? $clog2(COUNT) : 1;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int KS_W        = (KER_DIM > 1) ? $clog2(KER_DIM) : 1;

    typedef enum logic [1:0] {
        OP_PIXEL   = 2'd0,
        OP_WEIGHT  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // one step handed along the chain of accumulator cells
    typedef struct packed {
        logic               valid;
        logic signed [15:0] weight;
        logic signed [15:0] pixel;
        logic               clear;
    } tap_t;
endpackage

// ===== rtl/core/pmconv_cell.sv =====
`timescale 1ns / 1ps
module pmconv_cell
    import pmconv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  tap_t               tap_in,
    output tap_t               tap_out,
    output logic signed [31:0] acc
);
    tap_t               tap_reg;
    logic signed [31:0] prod_reg;
    logic               pv_reg;
    logic               pclr_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (pv_reg)
        begin
            acc_next = (pclr_reg ? 32'sd0 : acc_reg) + prod_reg;
        end
        else if (pclr_reg)
        begin
            acc_next = 32'sd0;
        end
    end

    // the word always moves on; it is only summed here when fire is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg  <= '0;
            pv_reg   <= 1'b0;
            pclr_reg <= 1'b0;
        end
        else
        begin
            tap_reg  <= tap_in;
            pv_reg   <= fire && tap_in.valid;
            pclr_reg <= fire && tap_in.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= tap_in.weight * tap_in.pixel;
        acc_reg  <= acc_next;
    end

    assign tap_out = tap_reg;
    assign acc     = acc_reg;
endmodule

// ===== rtl/core/padded_multichannel_conv2d.sv =====
`timescale 1ns / 1ps
// padded multichannel 2d convolution, stride one, zero padding
// command channel: an item is taken when start is high and busy is low
// opcode 0 writes a pixel, opcode 1 writes a weight
// opcode 2 computes one output row of the named filter
// a chain of one cell per output column holds the row's sums; for each
// channel and kernel tap the column words enter the head in reverse order,
// column COUNT-1 first, so when the column 0 word is at the head cell k
// holds the word for column k and every cell accumulates at once
// the single image read port sets the pace: a compute reads the words
// of every channel, kernel tap and column one after another
// the drain state then lets the chain settle, and the results leave one per cycle,
// column 0 first, strobed by valid, with row_last on the final column
// busy stays high until the last result has left
// the receiver cannot stall; reset clears control, the stores are not
// cleared and must be written before use
module padded_multichannel_conv2d
    import pmconv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [2:0]         filter_index,
    input  logic [1:0]         channel_index,
    input  logic [3:0]         row_index,
    input  logic [3:0]         col_index,
    input  logic signed [15:0] load_value,
    output logic               valid,
    output logic signed [31:0] conv_sum,
    output logic [2:0]         out_filter,
    output logic [3:0]         out_row,
    output logic [3:0]         out_col,
    output logic               row_last
);
    logic signed [15:0] image_mem [IMG_DEPTH];
    logic signed [15:0] weight_mem [WGT_DEPTH];

    state_t state_reg, state_next;
    logic [2:0] filt_reg;
    logic [3:0] row_reg;
    logic [CH_W-1:0] ch_reg;
    logic [KS_W-1:0] kr_reg, kc_reg;
    logic [COL_W-1:0] col_reg;
    logic [CNT_W+3:0] wait_reg;

    logic accept;
    assign accept = start && !busy;

    logic run_step, first_tap, last_tap;
    assign run_step  = (state_reg == ST_RUN);
    assign first_tap = (ch_reg == '0) && (kr_reg == '0) && (kc_reg == '0);
    assign last_tap  = (ch_reg == CH_W'(CHANNELS - 1)) && (kr_reg == KS_W'(KER_DIM - 1))
                       && (kc_reg == KS_W'(KER_DIM - 1));

    // image and weight read, registered
    logic signed [15:0] pix_reg, wgt_reg;
    logic               inb_reg, sv_reg, sclr_reg, fire_reg;
    logic signed [6:0]  ir, ic;
    logic               inb;
    always_comb
    begin
        ir  = 7'(row_reg) + 7'(kr_reg) - 7'(PAD);
        ic  = 7'(col_reg) + 7'(kc_reg) - 7'(PAD);
        inb = (ir >= 0) && (ir < IMG_DIM) && (ic >= 0) && (ic < IMG_DIM);
    end

    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_PIXEL && channel_index < CHANNELS
            && row_index < IMG_DIM && col_index < IMG_DIM)
        begin
            image_mem[IMG_AW'((channel_index * IMG_DIM + row_index) * IMG_DIM
                + col_index)] <= load_value;
        end
        if (accept && opcode == OP_WEIGHT && filter_index < FILTERS
            && channel_index < CHANNELS && row_index < KER_DIM
            && col_index < KER_DIM)
        begin
            weight_mem[WGT_AW'(((filter_index * CHANNELS + channel_index) * KER_DIM
                + row_index) * KER_DIM + col_index)] <= load_value;
        end
        pix_reg <= image_mem[IMG_AW'((ch_reg * IMG_DIM + (ir & 7'h3f)) * IMG_DIM
            + (ic & 7'h3f))];
        wgt_reg <= weight_mem[WGT_AW'(((filt_reg * CHANNELS + ch_reg) * KER_DIM + kr_reg)
            * KER_DIM + kc_reg)];
        inb_reg <= inb;
    end

    // the tap word enters the chain; cell k keeps column k
    // a word walks the chain, so the column words are injected in reverse
    // order: column COUNT-1 first
    tap_t head;
    always_comb
    begin
        head.valid  = sv_reg;
        head.weight = wgt_reg;
        head.pixel  = inb_reg ? pix_reg : 16'sd0;
        head.clear  = sclr_reg;
    end

    tap_t chain [COUNT+1];
    logic signed [31:0] accs [COUNT];
    assign chain[0] = head;

    genvar g;
    generate
        for (g = 0; g < COUNT; g++)
        begin : g_cell
            pmconv_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .fire   (fire_reg),
                .tap_in (chain[g]),
                .tap_out(chain[g+1]),
                .acc    (accs[g])
            );
        end
    endgenerate

    // fire when the column 0 word is at the head: the chain is then aligned
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg   <= 1'b0;
            sclr_reg <= 1'b0;
            fire_reg <= 1'b0;
        end
        else
        begin
            sv_reg   <= run_step;
            sclr_reg <= run_step && first_tap;
            fire_reg <= run_step && (col_reg == '0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_COMPUTE && filter_index < FILTERS
                    && row_index < OUT_SIZE && OUT_SIZE >= 1)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (col_reg == '0 && last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (wait_reg >= (CNT_W+4)'(COUNT + 4 - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            kr_reg    <= '0;
            kc_reg    <= '0;
            col_reg   <= '0;
            wait_reg  <= '0;
            filt_reg  <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                filt_reg <= filter_index;
                row_reg  <= row_index;
                ch_reg   <= '0;
                kr_reg   <= '0;
                kc_reg   <= '0;
                col_reg  <= COL_W'(COUNT - 1);
                wait_reg <= '0;
            end
            else if (state_reg == ST_RUN)
            begin
                if (col_reg != '0)
                begin
                    col_reg <= col_reg - 1'b1;
                end
                else
                begin
                    col_reg <= COL_W'(COUNT - 1);
                    if (kc_reg != KS_W'(KER_DIM - 1))
                    begin
                        kc_reg <= kc_reg + 1'b1;
                    end
                    else
                    begin
                        kc_reg <= '0;
                        if (kr_reg != KS_W'(KER_DIM - 1))
                        begin
                            kr_reg <= kr_reg + 1'b1;
                        end
                        else
                        begin
                            kr_reg <= '0;
                            if (ch_reg != CH_W'(CHANNELS - 1))
                            begin
                                ch_reg <= ch_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            else if (state_reg == ST_DRAIN)
            begin
                wait_reg <= wait_reg + 1'b1;
            end
        end
    end

    // results leave after the chain has settled, one column a cycle
    logic [CNT_W+3:0] oc;
    logic out_on;
    assign oc     = wait_reg - (CNT_W+4)'(4);
    assign out_on = (state_reg == ST_DRAIN) && wait_reg >= (CNT_W+4)'(4);

    always_comb
    begin
        conv_sum = '0;
        for (int k = 0; k < COUNT; k++)
        begin
            if (oc == (CNT_W+4)'(k))
            begin
                conv_sum = accs[k];
            end
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign valid      = out_on;
    assign out_filter = filt_reg;
    assign out_row    = row_reg;
    assign out_col    = oc[3:0];
    assign row_last   = out_on && oc == (CNT_W+4)'(COUNT - 1);
endmodule

// ===== bench/tb_padded_multichannel_conv2d.sv =====
`timescale 1ns / 1ps
module tb_padded_multichannel_conv2d;
    import pmconv_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [2:0]         filter_index;
    logic [1:0]         channel_index;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] load_value;
    logic               valid;
    logic signed [31:0] conv_sum;
    logic [2:0]         out_filter;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
    logic               row_last;

    typedef struct packed {
        logic [31:0] sum;
        logic [2:0]  filt;
        logic [3:0]  row;
        logic [3:0]  col;
        logic        last;
    } row_sum_t;

    // own copy of the stores, all entries written before any compute
    logic signed [15:0] pixel_mem [IMG_DEPTH];
    logic signed [15:0] weight_mem [WGT_DEPTH];
    row_sum_t           pending_sums [$];
    int                 error_count;
    bit                 no_idle;

    padded_multichannel_conv2d DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .filter_index(filter_index),
        .channel_index(channel_index), .row_index(row_index),
        .col_index(col_index), .load_value(load_value), .valid(valid),
        .conv_sum(conv_sum), .out_filter(out_filter), .out_row(out_row),
        .out_col(out_col), .row_last(row_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] sum_at(int f, int orow, int ocol);
        logic [31:0] acc;
        int ir;
        int ic;
        int w;
        int x;
        acc = 0;
        for (int ch = 0; ch < CHANNELS; ch++)
            for (int kr = 0; kr < KER_DIM; kr++)
                for (int kc = 0; kc < KER_DIM; kc++)
                begin
                    ir = orow + kr - PAD;
                    ic = ocol + kc - PAD;
                    if (ir >= 0 && ir < IMG_DIM && ic >= 0 && ic < IMG_DIM)
                    begin
                        w = weight_mem[((f * CHANNELS + ch) * KER_DIM + kr) * KER_DIM + kc];
                        x = pixel_mem[(ch * IMG_DIM + ir) * IMG_DIM + ic];
                        acc += 32'(w * x);
                    end
                end
        return acc;
    endfunction

    function automatic void predict_item(opcode_t op, int f, int ch, int r, int c,
                                         logic signed [15:0] v);
        row_sum_t s;
        case (op)
            OP_PIXEL:
                if (ch < CHANNELS && r < IMG_DIM && c < IMG_DIM)
                    pixel_mem[(ch * IMG_DIM + r) * IMG_DIM + c] = v;
            OP_WEIGHT:
                if (f < FILTERS && ch < CHANNELS && r < KER_DIM && c < KER_DIM)
                    weight_mem[((f * CHANNELS + ch) * KER_DIM + r) * KER_DIM + c] = v;
            OP_COMPUTE:
                if (OUT_SIZE >= 1 && f < FILTERS && r < OUT_SIZE)
                    for (int j = 0; j < COUNT; j++)
                    begin
                        s.sum  = sum_at(f, r, j);
                        s.filt = 3'(f);
                        s.row  = 4'(r);
                        s.col  = 4'(j);
                        s.last = (j == COUNT - 1);
                        pending_sums.push_back(s);
                    end
            default: ;
        endcase
    endfunction

    // start stays high after a transfer; the next item, an idle cycle or
    // wait_results takes it over
    task automatic send_item(opcode_t op, int f, int ch, int r, int c,
                             logic signed [15:0] v);
        if (!no_idle)
            while ($urandom_range(99) < 32)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start         <= 1'b1;
        opcode        <= op;
        filter_index  <= 3'(f);
        channel_index <= 2'(ch);
        row_index     <= 4'(r);
        col_index     <= 4'(c);
        load_value    <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_item(op, f, ch, r, c, v);
    endtask

    always @(posedge clk)
    begin
        row_sum_t e;
        if (rst_n && valid)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t: unexpected result col %0d sum %h", $time, out_col, conv_sum);
                error_count++;
            end
            else
            begin
                e = pending_sums.pop_front();
                if (e !== {conv_sum, out_filter, out_row, out_col, row_last})
                begin
                    $display("%0t: expected sum %h f %0d r %0d c %0d last %0b, got %h %0d %0d %0d %0b",
                             $time, e.sum, e.filt, e.row, e.col, e.last,
                             conv_sum, out_filter, out_row, out_col, row_last);
                    error_count++;
                end
            end
        end
    end

    task automatic wait_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    // fill every store entry so no compute reads an unwritten one
    task automatic test_fill_stores(bit extreme);
        for (int ch = 0; ch < CHANNELS; ch++)
            for (int r = 0; r < IMG_DIM; r++)
                for (int c = 0; c < IMG_DIM; c++)
                    send_item(OP_PIXEL, $urandom_range(7), ch, r, c,
                              extreme ? (($urandom_range(1)) ? 16'sh8000 : 16'sh7fff)
                                      : 16'($urandom));
        for (int f = 0; f < FILTERS; f++)
            for (int ch = 0; ch < CHANNELS; ch++)
                for (int r = 0; r < KER_DIM; r++)
                    for (int c = 0; c < KER_DIM; c++)
                        send_item(OP_WEIGHT, f, ch, r, c,
                                  extreme ? 16'sh8000 : 16'($urandom));
    endtask

    task automatic test_directed();
        // extremes give wrapping sums; edge rows exercise the padding
        send_item(OP_COMPUTE, 0, 0, 0, 0, 0);
        send_item(OP_COMPUTE, 7, 3, 15, 15, 16'sh7fff);
        // out of range weight loads are ignored
        send_item(OP_WEIGHT, 2, 1, 3, 0, 16'sh1234);
        send_item(OP_WEIGHT, 2, 1, 0, 15, 16'sh1234);
        // opcode three does nothing
        send_item(OP_NONE, 7, 3, 15, 15, 16'shffff);
        send_item(OP_COMPUTE, 2, 0, 7, 0, 0);
        send_item(OP_PIXEL, 0, 3, 15, 15, 16'sh8000);
        send_item(OP_WEIGHT, 7, 3, 2, 2, 16'sh7fff);
        send_item(OP_COMPUTE, 7, 0, 14, 0, 0);
    endtask

    task automatic test_random(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            no_idle = (i >= n / 2 && i < n / 2 + 15);
            k = $urandom_range(9);
            if (k < 4)
                send_item(OP_COMPUTE, $urandom_range(7), $urandom_range(3),
                          $urandom_range(15), $urandom_range(15), 16'($urandom));
            else if (k < 7)
                send_item(OP_PIXEL, $urandom_range(7), $urandom_range(3),
                          $urandom_range(15), $urandom_range(15), 16'($urandom));
            else if (k < 9)
                send_item(OP_WEIGHT, $urandom_range(7), $urandom_range(3),
                          $urandom_range(15), $urandom_range(15), 16'($urandom));
            else
                send_item(OP_NONE, $urandom_range(7), $urandom_range(3),
                          $urandom_range(15), $urandom_range(15), 16'($urandom));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_pause();
        wait_results();
        send_item(OP_COMPUTE, 5, 0, 8, 0, 0);
        wait_results();
    endtask

    initial
    begin
        error_count   = 0;
        no_idle       = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        opcode        = OP_NONE;
        filter_index  = '0;
        channel_index = '0;
        row_index     = '0;
        col_index     = '0;
        load_value    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_stores(1'b1);
        test_directed();
        test_pause();
        test_fill_stores(1'b0);
        test_random(110);
        wait_results();
        repeat (50) @(posedge clk);
        if (error_count == 0 && pending_sums.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
